FILE: rtl/udpdmx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UDP port demux package
// Types, sizes and codes shared by the UDP port demux table and its channels.
// ----------------------------------------------------------------------------
package udpdmx_pkg;

  localparam int unsigned SLOTS    = 16;
  localparam int unsigned TAG_BITS = 8;
  localparam int unsigned IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W    = $clog2(SLOTS + 1);

  localparam logic [15:0] UDP_HEADER_BYTES = 16'd8;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;

  typedef enum logic [1:0] {
    MODE_BIND   = 2'd0,
    MODE_UNBIND = 2'd1,
    MODE_RECV   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    STAT_DONE      = 3'd0,
    STAT_REJECTED  = 3'd1,
    STAT_DELIVERED = 3'd2,
    STAT_MALFORMED = 3'd3,
    STAT_UNREACH   = 3'd4,
    STAT_DROPPED   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } fsm_e;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] port;
    logic [7:0]  owner_tag;
    logic [15:0] source_port;
    logic [15:0] udp_length;
    logic [15:0] packet_length;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  slot_index;
    logic [7:0]  matched_owner;
    logic [15:0] peer_port;
    logic [31:0] peer_address;
    logic [15:0] payload_length;
    logic [4:0]  bound_total;
    logic [31:0] error_total;
    logic [31:0] drop_total;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/udpdmx_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UDP port demux input channel
// Valid/ready channel that carries one bind, unbind or receive item.
// ----------------------------------------------------------------------------
interface udpdmx_in_if
  import udpdmx_pkg::*;
();

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface
`default_nettype wire

FILE: rtl/udpdmx_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UDP port demux result channel
// Valid/ready channel that carries one result per input item.
// ----------------------------------------------------------------------------
interface udpdmx_out_if
  import udpdmx_pkg::*;
();

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface
`default_nettype wire

FILE: rtl/udp_port_demux_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UDP port demux table
// Table of listening UDP ports with bind, unbind and receive lookup.
// ----------------------------------------------------------------------------
// Channel    Direction  Handshake    Contents
// item_i     in         valid/ready  mode, port, tag and packet header fields
// result_o   out        valid/ready  status, slot, delivery data and totals
// cfg        in         write enable unreachable_enable
//
// An item is handled in steps: the port table is scanned one slot per cycle
// through a single port comparator, then a finish step settles the result.
// The result sits in an output register, so the next transaction is taken
// while it waits. A stalled output holds the block in its final step.
// Reset clears the table's used bits, the counters and the control state.
// ----------------------------------------------------------------------------
module udp_port_demux_table
  import udpdmx_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  udpdmx_in_if.sink      item_i,
  udpdmx_out_if.source   result_o,
  input  wire logic      cfg_we_i,
  input  wire logic      cfg_wdata_i
);

  fsm_e                state_q, state_d;
  logic [IDX_W-1:0]    idx_q;
  in_item_t            item_q;
  logic                hit_q, free_q;
  logic [IDX_W-1:0]    hit_idx_q, free_idx_q;
  logic [TAG_BITS-1:0] hit_owner_q;
  logic [SLOTS-1:0]    used_q;
  logic [15:0]         port_mem_q  [SLOTS];
  logic [TAG_BITS-1:0] owner_mem_q [SLOTS];
  logic [CNT_W-1:0]    used_count_q, used_count_d;
  logic [31:0]         err_q, err_d, drop_q, drop_d;
  logic                unreach_en_q;
  logic                out_valid_q;
  out_item_t           out_data_q;

  logic      in_ready, in_fire, fin_fire, scan_last;
  logic      cur_used, cur_hit;
  logic      malformed, do_bind, do_unbind;
  out_item_t res;

  assign in_fire   = item_i.valid && in_ready;
  assign scan_last = (idx_q == IDX_W'(SLOTS - 1));
  assign cur_used  = used_q[idx_q];
  assign cur_hit   = cur_used && (port_mem_q[idx_q] == item_q.port);

  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    fin_fire = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (item_i.valid) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || result_o.ready) begin
          fin_fire = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    malformed = (item_q.packet_length < UDP_HEADER_BYTES) ||
                (item_q.ip_protocol != PROTO_UDP) ||
                (item_q.udp_length < UDP_HEADER_BYTES) ||
                (item_q.udp_length > item_q.packet_length);
    do_bind      = 1'b0;
    do_unbind    = 1'b0;
    used_count_d = used_count_q;
    err_d        = err_q;
    drop_d       = drop_q;
    res          = '0;
    res.status   = STAT_REJECTED;
    case (item_q.mode)
      MODE_BIND: begin
        if ((item_q.port != 16'd0) && !hit_q && free_q) begin
          do_bind        = 1'b1;
          used_count_d   = used_count_q + CNT_W'(1);
          res.status     = STAT_DONE;
          res.slot_index = 4'(free_idx_q);
        end
      end
      MODE_UNBIND: begin
        if ((item_q.port != 16'd0) && hit_q) begin
          do_unbind      = 1'b1;
          if (used_count_q != '0) begin
            used_count_d = used_count_q - CNT_W'(1);
          end
          res.status     = STAT_DONE;
          res.slot_index = 4'(hit_idx_q);
        end
      end
      MODE_RECV: begin
        if (malformed) begin
          res.status = STAT_MALFORMED;
          err_d      = (err_q == '1) ? err_q : err_q + 32'd1;
        end else if (hit_q) begin
          res.status         = STAT_DELIVERED;
          res.slot_index     = 4'(hit_idx_q);
          res.matched_owner  = 8'(hit_owner_q);
          res.peer_port      = item_q.source_port;
          res.peer_address   = item_q.source_address;
          res.payload_length = item_q.packet_length - UDP_HEADER_BYTES;
        end else if (unreach_en_q) begin
          res.status = STAT_UNREACH;
        end else begin
          res.status = STAT_DROPPED;
          drop_d     = (drop_q == '1) ? drop_q : drop_q + 32'd1;
        end
      end
      default: begin
        res.status = STAT_REJECTED;
      end
    endcase
    res.bound_total = 5'(used_count_d);
    res.error_total = err_d;
    res.drop_total  = drop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      used_q       <= '0;
      used_count_q <= '0;
      err_q        <= '0;
      drop_q       <= '0;
      unreach_en_q <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unreach_en_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        idx_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (state_q == S_SCAN) begin
        idx_q <= idx_q + IDX_W'(1);
        if (cur_hit) begin
          hit_q <= 1'b1;
        end
        if (!cur_used) begin
          free_q <= 1'b1;
        end
      end
      if (fin_fire) begin
        used_count_q <= used_count_d;
        err_q        <= err_d;
        drop_q       <= drop_d;
        out_valid_q  <= 1'b1;
        if (do_bind) begin
          used_q[free_idx_q] <= 1'b1;
        end
        if (do_unbind) begin
          used_q[hit_idx_q] <= 1'b0;
        end
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= item_i.data;
    end
    if ((state_q == S_SCAN) && cur_hit && !hit_q) begin
      hit_idx_q   <= idx_q;
      hit_owner_q <= owner_mem_q[idx_q];
    end
    if ((state_q == S_SCAN) && !cur_used && !free_q) begin
      free_idx_q <= idx_q;
    end
    if (fin_fire) begin
      out_data_q <= res;
      if (do_bind) begin
        port_mem_q[free_idx_q]  <= item_q.port;
        owner_mem_q[free_idx_q] <= TAG_BITS'(item_q.owner_tag);
      end
    end
  end

  assign item_i.ready   = in_ready;
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

`ifndef SYNTHESIS
  a_count_matches_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_count_q == CNT_W'($countones(used_q)))
    else $error("Bound slot count disagrees with the used bits.");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> (state_q == S_SCAN && idx_q == '0))
    else $error("An accepted transaction did not start a scan at slot zero.");

  a_finish_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_fire |=> (out_valid_q && state_q == S_IDLE))
    else $error("A finished item did not load the result register.");
`endif

endmodule
`default_nettype wire
